### sv/assert_macros.svh
// assertion macros shared by the bank mapper rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rbm_pkg.sv
// types, codes and the page reduction table for the rom bank mapper
// no dependencies
`default_nettype none

package rbm_pkg;

  localparam int unsigned MAX_PRG_PAGES_DEF = 256;

  localparam int unsigned CNT_W     = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OFFSET_W  = 21;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned REQ_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_PAGES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_PAGES = 1'b1;

  localparam logic [CNT_W-1:0] PRG_PAGES_RST = 9'd2;
  localparam logic [CNT_W-1:0] CHR_PAGES_RST = 9'd0;

  localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;

  // bank select commands, low three bits of the control byte
  localparam logic [2:0] CMD_CHR_2K_LAST = 3'd1;
  localparam logic [2:0] CMD_PRG_FIRST   = 3'd6;

  // write decode: address bits 15..13 and bit 0
  typedef enum logic [3:0] {
    WR_CTRL    = 4'b1000,
    WR_BANK    = 4'b1001,
    WR_MIRROR  = 4'b1010,
    WR_SRAM    = 4'b1011,
    WR_RELOAD  = 4'b1100,
    WR_CLEAR   = 4'b1101,
    WR_IRQ_OFF = 4'b1110,
    WR_IRQ_ON  = 4'b1111
  } wr_reg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] prg_offset;
    logic                chr_copy;
    logic [2:0]          chr_slot;
    logic [7:0]          chr_page;
    logic                mirror_horizontal;
    logic                irq;
    logic                last;
  } rbm_result_t;

  typedef struct packed {
    logic        valid;
    logic        two;
    rbm_result_t first;
    rbm_result_t second;
  } rbm_push_t;

  // i mod m for i in 0..255, built by counting so no divide is needed
  function automatic logic [255:0][7:0] mod_table(input int unsigned m);
    logic [255:0][7:0] t;
    int unsigned r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'(r);
      r = (r + 1 == m) ? 0 : r + 1;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

### sv/rbm_ifs.sv
// valid/ready stream interfaces for the bank mapper request and result channels
// depends on rbm_pkg
`default_nettype none

interface rbm_in_if
  import rbm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] wdata;

  modport source (output valid, output req_type, output addr, output wdata, input ready);
  modport sink (input valid, input req_type, input addr, input wdata, output ready);
endinterface

interface rbm_out_if
  import rbm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] prg_offset;
  logic                chr_copy;
  logic [2:0]          chr_slot;
  logic [7:0]          chr_page;
  logic                mirror_horizontal;
  logic                irq;
  logic                last;

  modport source (output valid, output prg_offset, output chr_copy, output chr_slot,
                  output chr_page, output mirror_horizontal, output irq, output last,
                  input ready);
  modport sink (input valid, input prg_offset, input chr_copy, input chr_slot,
                input chr_page, input mirror_horizontal, input irq, input last,
                output ready);
endinterface

`default_nettype wire

### sv/rbm_core.sv
// mapper state, address translation, write decode and scanline counter
// depends on rbm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rbm_core
  import rbm_pkg::*;
#(
  parameter int unsigned MAX_PRG_PAGES = MAX_PRG_PAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_wdata,
  input  wire logic                 accept,
  input  wire logic [REQ_W-1:0]     req_type,
  input  wire logic [ADDR_W-1:0]    addr,
  input  wire logic [DATA_W-1:0]    wdata,
  output rbm_push_t                 push
);

  localparam logic [255:0][7:0] MOD_TBL = mod_table(MAX_PRG_PAGES);
  localparam logic [7:0]        MOD_256 = 8'(256 % MAX_PRG_PAGES);
  localparam logic [CNT_W-1:0]  MOD_M   = CNT_W'(MAX_PRG_PAGES);

  logic [CNT_W-1:0] prg_cnt_r, prg_cnt_nxt;
  logic [CNT_W-1:0] chr_cnt_r, chr_cnt_nxt;
  logic [7:0]       ctrl_r, ctrl_nxt;
  logic [7:0]       bank_first_r, bank_first_nxt;
  logic [7:0]       bank_second_r, bank_second_nxt;
  logic [7:0]       lc_r, lc_nxt;
  logic [7:0]       reload_r, reload_nxt;
  logic             irq_en_r, irq_en_nxt;
  logic             mirror_r, mirror_nxt;

  // read translation
  logic [1:0]       window;
  logic [1:0]       sel;
  logic [CNT_W-1:0] prg_mask;
  logic [CNT_W-1:0] fixed_page;
  logic [CNT_W-1:0] page_raw;
  logic [CNT_W-1:0] page_and;
  logic [CNT_W-1:0] page_sum;
  logic [CNT_W-1:0] page_red;

  // character side
  logic [CNT_W-1:0] chr_mask;
  logic [2:0]       cmd;
  logic [2:0]       inv;
  logic [2:0]       slot_2k;
  logic [7:0]       page_lo;
  logic [7:0]       page_hi;
  logic [7:0]       page_1k;
  wr_reg_t          wr_reg;

  always_comb begin
    window     = addr[14:13];
    sel        = (window - {1'b0, ctrl_r[6]}) ^ {1'b0, ctrl_r[6]};
    prg_mask   = prg_cnt_r - CNT_W'(1);
    fixed_page = prg_cnt_r - CNT_W'(2) + {{(CNT_W-1){1'b0}}, window[0]};
    case (sel)
      2'd0:    page_raw = {1'b0, bank_first_r};
      2'd1:    page_raw = {1'b0, bank_second_r};
      default: page_raw = fixed_page;
    endcase
    page_and = page_raw & prg_mask;
    // mod by a constant: table for the low byte, folded-in weight of bit 8
    page_sum = {1'b0, MOD_TBL[page_and[7:0]]}
             + (page_and[8] ? {1'b0, MOD_256} : CNT_W'(0));
    page_red = (page_sum >= MOD_M) ? page_sum - MOD_M : page_sum;
  end

  always_comb begin
    chr_mask = chr_cnt_r - CNT_W'(1);
    cmd      = ctrl_r[2:0];
    inv      = {ctrl_r[7], 2'b00};
    slot_2k  = {1'b0, cmd[0], 1'b0} ^ inv;
    page_lo  = (wdata & 8'hFE) & chr_mask[7:0];
    page_hi  = (wdata | 8'h01) & chr_mask[7:0];
    page_1k  = wdata & chr_mask[7:0];
    wr_reg   = wr_reg_t'({addr[15:13], addr[0]});
  end

  always_comb begin
    prg_cnt_nxt     = prg_cnt_r;
    chr_cnt_nxt     = chr_cnt_r;
    ctrl_nxt        = ctrl_r;
    bank_first_nxt  = bank_first_r;
    bank_second_nxt = bank_second_r;
    lc_nxt          = lc_r;
    reload_nxt      = reload_r;
    irq_en_nxt      = irq_en_r;
    mirror_nxt      = mirror_r;
    push            = '0;
    push.first.last = 1'b1;

    if (cfg_we) begin
      if (cfg_index == CFG_PRG_PAGES) prg_cnt_nxt = cfg_wdata;
      else chr_cnt_nxt = cfg_wdata;
    end

    if (accept) begin
      push.valid = 1'b1;
      if (req_type == REQ_READ) begin
        push.first.prg_offset = {page_red[7:0], addr[12:0]};
      end else if (req_type == REQ_WRITE) begin
        unique case (wr_reg)
          WR_CTRL:   ctrl_nxt = wdata;
          WR_BANK: begin
            if (cmd >= CMD_PRG_FIRST) begin
              if (ctrl_r[0]) bank_second_nxt = wdata;
              else bank_first_nxt = wdata;
            end else if (chr_cnt_r != '0) begin
              push.first.chr_copy = 1'b1;
              if (cmd <= CMD_CHR_2K_LAST) begin
                push.two               = 1'b1;
                push.first.chr_slot    = slot_2k;
                push.first.chr_page    = page_lo;
                push.first.last        = 1'b0;
                push.second.chr_copy   = 1'b1;
                push.second.chr_slot   = slot_2k | 3'd1;
                push.second.chr_page   = page_hi;
                push.second.last       = 1'b1;
              end else begin
                push.first.chr_slot = (cmd + 3'd2) ^ inv;
                push.first.chr_page = page_1k;
              end
            end
          end
          WR_MIRROR:  mirror_nxt = wdata[0];
          WR_RELOAD:  reload_nxt = wdata;
          WR_CLEAR:   lc_nxt     = '0;
          WR_IRQ_OFF: irq_en_nxt = 1'b0;
          WR_IRQ_ON:  irq_en_nxt = 1'b1;
          default: ;
        endcase
      end else begin
        if (lc_r == '0) begin
          lc_nxt = reload_r;
        end else begin
          lc_nxt         = lc_r - 8'd1;
          push.first.irq = (lc_r == 8'd1) && irq_en_r;
        end
      end
    end

    push.first.mirror_horizontal  = mirror_nxt;
    push.second.mirror_horizontal = mirror_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_cnt_r     <= PRG_PAGES_RST;
      chr_cnt_r     <= CHR_PAGES_RST;
      ctrl_r        <= '0;
      bank_first_r  <= '0;
      bank_second_r <= 8'd1;
      lc_r          <= '0;
      reload_r      <= '0;
      irq_en_r      <= 1'b0;
      mirror_r      <= 1'b0;
    end else begin
      prg_cnt_r     <= prg_cnt_nxt;
      chr_cnt_r     <= chr_cnt_nxt;
      ctrl_r        <= ctrl_nxt;
      bank_first_r  <= bank_first_nxt;
      bank_second_r <= bank_second_nxt;
      lc_r          <= lc_nxt;
      reload_r      <= reload_nxt;
      irq_en_r      <= irq_en_nxt;
      mirror_r      <= mirror_nxt;
    end
  end

  `RBM_ASSERT(a_two_are_copies, push.valid && push.two |-> push.first.chr_copy && push.second.chr_copy && !push.first.last && push.second.last, "two-result item must be a pair of copies")
  `RBM_ASSERT(a_irq_only_tick, push.valid && push.first.irq |-> req_type != REQ_READ && req_type != REQ_WRITE && irq_en_r, "irq raised outside an enabled tick")
  `RBM_ASSERT(a_tick_reload, accept && req_type != REQ_READ && req_type != REQ_WRITE && lc_r == '0 |=> lc_r == $past(reload_r), "counter not reloaded at zero")

endmodule

`default_nettype wire

### sv/rbm_outq.sv
// four-entry result queue, takes one or two results per transaction
// depends on rbm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rbm_outq
  import rbm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rbm_push_t push,
  output logic           room,
  output logic           head_valid,
  output rbm_result_t    head,
  input  wire logic      pop
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  rbm_result_t         mem_r [DEPTH];
  logic [PTR_W-1:0]    wptr_r, wptr_nxt;
  logic [PTR_W-1:0]    rptr_r, rptr_nxt;
  logic [CNT_QW-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]    wptr_p1;
  logic [CNT_QW-1:0]   n_in;

  always_comb begin
    // room for the largest item, so an accepted item never overflows the queue
    room       = count_r <= CNT_QW'(DEPTH - 2);
    head_valid = count_r != '0;
    head       = mem_r[rptr_r];
    wptr_p1    = wptr_r + PTR_W'(1);
    n_in       = push.valid ? (push.two ? CNT_QW'(2) : CNT_QW'(1)) : CNT_QW'(0);
    wptr_nxt   = wptr_r + n_in[PTR_W-1:0];
    rptr_nxt   = pop ? rptr_r + PTR_W'(1) : rptr_r;
    count_nxt  = count_r + n_in - (pop ? CNT_QW'(1) : CNT_QW'(0));
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wptr_r] <= push.first;
      if (push.two) mem_r[wptr_p1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  `RBM_ASSERT(a_count_bound, count_r <= CNT_QW'(DEPTH), "queue count beyond depth")
  `RBM_ASSERT(a_no_overflow, push.valid |-> count_r <= CNT_QW'(DEPTH - 2), "push without room")
  `RBM_ASSERT(a_ptr_track, 1'b1 |=> wptr_r - rptr_r == count_r[PTR_W-1:0], "pointers disagree with count")

endmodule

`default_nettype wire

### sv/rom_bank_mapper_with_line_irq.sv
// cartridge rom bank mapper with scanline interrupt counter
// each request's results are registered in the result queue and offered from its head in request order
// throughput: one request per cycle, save for the pauses below; a two-copy bank write yields two results
// intake pauses only when the four-entry result queue has fewer than two free slots
// synchronous active-low reset: counts 2 and 0, bank two at page 1, all else zero
`default_nettype none

module rom_bank_mapper_with_line_irq
  import rbm_pkg::*;
#(
  parameter int unsigned MAX_PRG_PAGES = MAX_PRG_PAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_wdata,
  rbm_in_if.sink                    in_ch,
  rbm_out_if.source                 out_ch
);

  rbm_push_t   push;
  rbm_result_t head;
  logic        room;
  logic        head_valid;
  logic        accept;
  logic        pop;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;
  assign pop         = head_valid && out_ch.ready;

  rbm_core #(
    .MAX_PRG_PAGES(MAX_PRG_PAGES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .req_type (in_ch.req_type),
    .addr     (in_ch.addr),
    .wdata    (in_ch.wdata),
    .push     (push)
  );

  rbm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  assign out_ch.valid             = head_valid;
  assign out_ch.prg_offset        = head.prg_offset;
  assign out_ch.chr_copy          = head.chr_copy;
  assign out_ch.chr_slot          = head.chr_slot;
  assign out_ch.chr_page          = head.chr_page;
  assign out_ch.mirror_horizontal = head.mirror_horizontal;
  assign out_ch.irq               = head.irq;
  assign out_ch.last              = head.last;

endmodule

`default_nettype wire
